/* rtl/cpdd_pkg.sv */
// shared types, widths and constants of the cascaded pd / pi drive controller
package cpdd_pkg;

  localparam int POS_W   = 9;   // ball and target coordinates
  localparam int PERR_W  = 10;  // integer position error
  localparam int TG_W    = 12;  // q4.8 turn gain
  localparam int GAIN_W  = 16;  // q8.8 loop gains
  localparam int CFG_W   = 16;  // widest register
  localparam int IDX_W   = 3;
  localparam int VEL_W   = 19;  // saturated velocity, 8 fraction bits
  localparam int TURN_W  = 23;  // floored turn term
  localparam int MIX_W   = 25;  // wheel target minus measured speed
  localparam int ERR_W   = 22;  // saturated speed error
  localparam int MUL_A_W = 23;  // signed multiplier operand
  localparam int MAC_W   = 41;  // multiply-accumulate register
  localparam int OUT_W   = 13;  // pwm output

  localparam logic [IDX_W-1:0] REG_AIM_X      = 3'd0;
  localparam logic [IDX_W-1:0] REG_AIM_Y      = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEER_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_POS_KP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_POS_KD     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SPD_KP     = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPD_KI     = 3'd6;

  localparam logic signed [ERR_W-1:0] ERR_HI = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_LO = {1'b1, {(ERR_W-1){1'b0}}};

  typedef struct packed {
    logic [POS_W-1:0]  aim_x;
    logic [POS_W-1:0]  aim_y;
    logic [TG_W-1:0]   steer_gain;
    logic [GAIN_W-1:0] pos_kp;
    logic [GAIN_W-1:0] pos_kd;
    logic [GAIN_W-1:0] spd_kp;
    logic [GAIN_W-1:0] spd_ki;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_PX0  = 13'b0000000000010,
    ST_PX1  = 13'b0000000000100,
    ST_PY0  = 13'b0000000001000,
    ST_PY1  = 13'b0000000010000,
    ST_TURN = 13'b0000000100000,
    ST_MIX  = 13'b0000001000000,
    ST_L0   = 13'b0000010000000,
    ST_L1   = 13'b0000100000000,
    ST_R0   = 13'b0001000000000,
    ST_R1   = 13'b0010000000000,
    ST_FIN  = 13'b0100000000000,
    ST_OUT  = 13'b1000000000000
  } state_t;

  // clamp a wheel error to the speed error range
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [MIX_W-1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > MIX_W'(ERR_HI)) r = ERR_HI;
    else if (v < MIX_W'(ERR_LO)) r = ERR_LO;
    else r = v[ERR_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/cascaded_pid_differential_drive.sv */
// cascaded pd position / incremental pi speed controller for a two-wheel drive
//
//  channel | signals                                          | direction
//  in      | in_valid in_ready ball_x ball_y left/right_speed | to block
//  out     | out_valid out_ready duty_left duty_right         | from block
//  cfg     | cfg_we cfg_index cfg_data                        | to block
//
// one item passes through 12 sequencer steps that use one shared 23x17
// multiply-accumulate unit (nine products), after the idle state that takes it.
// synchronous reset restores register defaults and clears all loop state.
// a result not yet taken holds the sequencer in its last step; the next
// input is taken once the result is loaded into the output register.
module cascaded_pid_differential_drive #(
  parameter int SPEED_BITS = 12,
  parameter int POS_LIMIT  = 300,
  parameter int PWM_LIMIT  = 3000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cpdd_pkg::POS_W-1:0]        ball_x,
  input  logic [cpdd_pkg::POS_W-1:0]        ball_y,
  input  logic signed [SPEED_BITS-1:0]      left_speed,
  input  logic signed [SPEED_BITS-1:0]      right_speed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cpdd_pkg::OUT_W-1:0] duty_left,
  output logic signed [cpdd_pkg::OUT_W-1:0] duty_right,
  input  logic                              cfg_we,
  input  logic [cpdd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [cpdd_pkg::CFG_W-1:0]        cfg_data
);
  import cpdd_pkg::*;

  localparam int PWM_Q = PWM_LIMIT * 256;
  localparam int ACC_W = $clog2(PWM_Q + 1) + 1;
  localparam int SUM_W = MAC_W - 8 + 1;
  localparam logic signed [MAC_W-1:0] POS_HI = MAC_W'(POS_LIMIT * 256);
  localparam logic signed [MAC_W-1:0] POS_LO = -POS_HI;
  localparam logic signed [SUM_W-1:0] PWM_HI = SUM_W'(PWM_Q);
  localparam logic signed [SUM_W-1:0] PWM_LO = -PWM_HI;

  cfg_t     cfg;
  mac_ctl_t mac_ctl;
  state_t   state, state_next;

  logic signed [MUL_A_W-1:0] mac_a;
  logic [GAIN_W-1:0]         mac_b;
  logic signed [MAC_W-1:0]   mac;

  logic [POS_W-1:0]           bx, by;
  logic signed [SPEED_BITS-1:0] sl, sr;
  logic signed [PERR_W-1:0]   prev_x, prev_y;
  logic signed [VEL_W-1:0]    vx, vy;
  logic signed [ERR_W-1:0]    err_l, err_r, prev_l, prev_r;
  logic signed [ACC_W-1:0]    acc_l, acc_r;

  logic signed [PERR_W-1:0]   err_x, err_y;
  logic signed [VEL_W-1:0]    vel_sat;
  logic signed [TURN_W-1:0]   turn;
  logic signed [MIX_W-1:0]    tgt_l, tgt_r, sl_q, sr_q;
  logic signed [ACC_W-1:0]    acc_cur, acc_new;
  logic signed [SUM_W-1:0]    acc_sum;
  logic signed [SUM_W-1:0]    ql, qr;

  cpdd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cpdd_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac)
  );

  assign in_ready = (state == ST_IDLE);

  assign err_x = $signed({1'b0, cfg.aim_x}) - $signed({1'b0, bx});
  assign err_y = $signed({1'b0, cfg.aim_y}) - $signed({1'b0, by});

  // position pd output clamp
  always_comb begin
    if (mac > POS_HI) vel_sat = POS_HI[VEL_W-1:0];
    else if (mac < POS_LO) vel_sat = POS_LO[VEL_W-1:0];
    else vel_sat = mac[VEL_W-1:0];
  end

  // differential mixing and speed errors
  assign turn  = mac[TURN_W+7:8];
  assign sl_q  = {{(MIX_W-SPEED_BITS-8){sl[SPEED_BITS-1]}}, sl, 8'd0};
  assign sr_q  = {{(MIX_W-SPEED_BITS-8){sr[SPEED_BITS-1]}}, sr, 8'd0};
  assign tgt_l = MIX_W'(vy) - MIX_W'(turn) - sl_q;
  assign tgt_r = MIX_W'(vy) + MIX_W'(turn) - sr_q;

  // pwm accumulator update, floored increment
  assign acc_cur = (state == ST_R0) ? acc_l : acc_r;
  assign acc_sum = SUM_W'(acc_cur) + SUM_W'($signed(mac[MAC_W-1:8]));
  always_comb begin
    if (acc_sum > PWM_HI) acc_new = PWM_HI[ACC_W-1:0];
    else if (acc_sum < PWM_LO) acc_new = PWM_LO[ACC_W-1:0];
    else acc_new = acc_sum[ACC_W-1:0];
  end

  // truncate toward zero
  assign ql = (SUM_W'(acc_l) >>> 8) + SUM_W'(acc_l < 0 && acc_l[7:0] != 8'd0);
  assign qr = (SUM_W'(acc_r) >>> 8) + SUM_W'(acc_r < 0 && acc_r[7:0] != 8'd0);

  // sequencer and operand select
  always_comb begin
    state_next  = state;
    mac_ctl.en  = 1'b0;
    mac_ctl.clr = 1'b0;
    mac_a       = '0;
    mac_b       = '0;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_PX0;
      ST_PX0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a = MUL_A_W'(err_x);
        mac_b = cfg.pos_kp;
        state_next = ST_PX1;
      end
      ST_PX1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a = MUL_A_W'(err_x) - MUL_A_W'(prev_x);
        mac_b = cfg.pos_kd;
        state_next = ST_PY0;
      end
      ST_PY0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a = MUL_A_W'(err_y);
        mac_b = cfg.pos_kp;
        state_next = ST_PY1;
      end
      ST_PY1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a = MUL_A_W'(err_y) - MUL_A_W'(prev_y);
        mac_b = cfg.pos_kd;
        state_next = ST_TURN;
      end
      ST_TURN: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a = MUL_A_W'(vx);
        mac_b = GAIN_W'(cfg.steer_gain);
        state_next = ST_MIX;
      end
      ST_MIX: state_next = ST_L0;
      ST_L0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a = MUL_A_W'(err_l) - MUL_A_W'(prev_l);
        mac_b = cfg.spd_kp;
        state_next = ST_L1;
      end
      ST_L1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a = MUL_A_W'(err_l);
        mac_b = cfg.spd_ki;
        state_next = ST_R0;
      end
      ST_R0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a = MUL_A_W'(err_r) - MUL_A_W'(prev_r);
        mac_b = cfg.spd_kp;
        state_next = ST_R1;
      end
      ST_R1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a = MUL_A_W'(err_r);
        mac_b = cfg.spd_ki;
        state_next = ST_FIN;
      end
      ST_FIN: state_next = ST_OUT;
      ST_OUT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      prev_x <= '0;
      prev_y <= '0;
      prev_l <= '0;
      prev_r <= '0;
      acc_l  <= '0;
      acc_r  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_PX1:  prev_x <= err_x;
        ST_PY1:  prev_y <= err_y;
        ST_L1:   prev_l <= err_l;
        ST_R0:   acc_l  <= acc_new;
        ST_R1:   prev_r <= err_r;
        ST_FIN:  acc_r  <= acc_new;
        default: ;
      endcase
    end
  end

  // item payload and intermediate values
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          bx <= ball_x;
          by <= ball_y;
          sl <= left_speed;
          sr <= right_speed;
        end
      end
      ST_PY0:  vx <= vel_sat;
      ST_TURN: vy <= vel_sat;
      ST_MIX: begin
        err_l <= sat_err(tgt_l);
        err_r <= sat_err(tgt_r);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      duty_left  <= ql[OUT_W-1:0];
      duty_right <= qr[OUT_W-1:0];
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transfer is in progress");

  a_acc_l_bound: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(acc_l) <= PWM_HI && SUM_W'(acc_l) >= PWM_LO)
    else $error("left pwm accumulator out of range");

  a_acc_r_bound: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(acc_r) <= PWM_HI && SUM_W'(acc_r) >= PWM_LO)
    else $error("right pwm accumulator out of range");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && (!out_valid || out_ready) |=> out_valid && in_ready)
    else $error("result not loaded at end of sequence");

  a_result_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && out_valid && !out_ready |=> state == ST_OUT)
    else $error("sequencer left while result pending");

endmodule

/* rtl/cpdd_cfg.sv */
// configuration register file
module cpdd_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cpdd_pkg::IDX_W-1:0] cfg_index,
  input  logic [cpdd_pkg::CFG_W-1:0] cfg_data,
  output cpdd_pkg::cfg_t             cfg
);
  import cpdd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aim_x      <= POS_W'(160);
      cfg.aim_y      <= POS_W'(160);
      cfg.steer_gain <= TG_W'(256);
      cfg.pos_kp     <= GAIN_W'(6477);
      cfg.pos_kd     <= GAIN_W'(128);
      cfg.spd_kp     <= GAIN_W'(128);
      cfg.spd_ki     <= GAIN_W'(768);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AIM_X:      cfg.aim_x      <= cfg_data[POS_W-1:0];
        REG_AIM_Y:      cfg.aim_y      <= cfg_data[POS_W-1:0];
        REG_STEER_GAIN: cfg.steer_gain <= cfg_data[TG_W-1:0];
        REG_POS_KP:     cfg.pos_kp     <= cfg_data[GAIN_W-1:0];
        REG_POS_KD:     cfg.pos_kd     <= cfg_data[GAIN_W-1:0];
        REG_SPD_KP:     cfg.spd_kp     <= cfg_data[GAIN_W-1:0];
        REG_SPD_KI:     cfg.spd_ki     <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/cpdd_mac.sv */
// shared signed by unsigned multiply-accumulate unit
module cpdd_mac (
  input  logic                               clk,
  input  cpdd_pkg::mac_ctl_t                 ctl,
  input  logic signed [cpdd_pkg::MUL_A_W-1:0] a,
  input  logic [cpdd_pkg::GAIN_W-1:0]        b,
  output logic signed [cpdd_pkg::MAC_W-1:0]  acc
);
  import cpdd_pkg::*;

  logic signed [GAIN_W:0]  b_s;
  logic signed [MAC_W-1:0] prod;
  logic signed [MAC_W-1:0] base;

  assign b_s  = $signed({1'b0, b});
  assign prod = MAC_W'(a * b_s);
  assign base = ctl.clr ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + prod;
    end
  end

endmodule

/* tb/sv/tb_cascaded_pid_differential_drive.sv */
// testbench for the cascaded pd position / incremental pi speed drive controller
`timescale 1ns / 1ps

module tb_cascaded_pid_differential_drive;
  import cpdd_pkg::*;

  localparam int SPD_W = 12;
  localparam longint VEL_LIM = 300 * 256;
  localparam longint DRIVE_LIM = 3000 * 256;
  localparam longint WERR_HI = 2097151;
  localparam longint WERR_LO = -2097152;
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;

  class pwm_scoreboard;
    cfg_t regs;
    longint last_ex, last_ey, last_el, last_er;
    longint drive_l, drive_r;
    logic signed [OUT_W-1:0] want_l[$];
    logic signed [OUT_W-1:0] want_r[$];
    int bad;

    function new();
      regs.aim_x = 9'd160;
      regs.aim_y = 9'd160;
      regs.steer_gain = 12'd256;
      regs.pos_kp = 16'd6477;
      regs.pos_kd = 16'd128;
      regs.spd_kp = 16'd128;
      regs.spd_ki = 16'd768;
      last_ex = 0;
      last_ey = 0;
      last_el = 0;
      last_er = 0;
      drive_l = 0;
      drive_r = 0;
      bad = 0;
    endfunction

    function longint clamp(longint v, longint lim);
      return v < -lim ? -lim : (v > lim ? lim : v);
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_AIM_X:      regs.aim_x = data[POS_W-1:0];
        REG_AIM_Y:      regs.aim_y = data[POS_W-1:0];
        REG_STEER_GAIN: regs.steer_gain = data[TG_W-1:0];
        REG_POS_KP:     regs.pos_kp = data;
        REG_POS_KD:     regs.pos_kd = data;
        REG_SPD_KP:     regs.spd_kp = data;
        REG_SPD_KI:     regs.spd_ki = data;
        default: ;
      endcase
    endfunction

    // pd position loop, velocity with 8 fraction bits
    function longint pd_vel(logic [POS_W-1:0] tgt, logic [POS_W-1:0] meas, inout longint last);
      longint e, v;
      e = longint'(tgt) - longint'(meas);
      v = longint'(regs.pos_kp) * e + longint'(regs.pos_kd) * (e - last);
      last = e;
      return clamp(v, VEL_LIM);
    endfunction

    // incremental pi speed loop, accumulator with 8 fraction bits
    function longint pi_drive(longint tgt, logic signed [SPD_W-1:0] meas,
                              inout longint last, inout longint acc);
      longint e, step;
      e = tgt - longint'(meas) * 256;
      if (e > WERR_HI) e = WERR_HI;
      else if (e < WERR_LO) e = WERR_LO;
      step = (longint'(regs.spd_kp) * (e - last) + longint'(regs.spd_ki) * e) >>> 8;
      last = e;
      acc = clamp(acc + step, DRIVE_LIM);
      return acc;
    endfunction

    function void note_input(logic [POS_W-1:0] bx, logic [POS_W-1:0] by,
                             logic signed [SPD_W-1:0] ls, logic signed [SPD_W-1:0] rs);
      longint vx, vy, turn, al, ar;
      vx = pd_vel(regs.aim_x, bx, last_ex);
      vy = pd_vel(regs.aim_y, by, last_ey);
      turn = (vx * longint'(regs.steer_gain)) >>> 8;
      al = pi_drive(vy - turn, ls, last_el, drive_l) / 256;
      ar = pi_drive(vy + turn, rs, last_er, drive_r) / 256;
      want_l.push_back(al[OUT_W-1:0]);
      want_r.push_back(ar[OUT_W-1:0]);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] pl, logic signed [OUT_W-1:0] pr);
      logic signed [OUT_W-1:0] el, er;
      if (want_l.size() == 0) begin
        bad++;
        if (bad <= 10) $display("unexpected pwm transfer: left %0d right %0d", pl, pr);
        return;
      end
      el = want_l.pop_front();
      er = want_r.pop_front();
      if (pl !== el || pr !== er) begin
        bad++;
        if (bad <= 10)
          $display("pwm mismatch: expected left %0d right %0d, got left %0d right %0d",
                   el, er, pl, pr);
      end
    endfunction

    function int pending();
      return want_l.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [POS_W-1:0] ball_x = '0;
  logic [POS_W-1:0] ball_y = '0;
  logic signed [SPD_W-1:0] left_speed = '0;
  logic signed [SPD_W-1:0] right_speed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] duty_left;
  logic signed [OUT_W-1:0] duty_right;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic quiet = 1'b0;
  int unsigned cycles = 0;
  int walk_x, walk_y, walk_l, walk_r;
  cfg_t active;
  pwm_scoreboard sb;

  cascaded_pid_differential_drive dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ball_x(ball_x),
    .ball_y(ball_y),
    .left_speed(left_speed),
    .right_speed(right_speed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .duty_left(duty_left),
    .duty_right(duty_right),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(ball_x, ball_y, left_speed, right_speed);
      if (out_valid && out_ready) sb.check_result(duty_left, duty_right);
    end
  end

  task automatic send_item(input int bx, input int by, input int ls, input int rs);
    in_valid <= 1'b1;
    ball_x <= bx[POS_W-1:0];
    ball_y <= by[POS_W-1:0];
    left_speed <= ls[SPD_W-1:0];
    right_speed <= rs[SPD_W-1:0];
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic load_regs(input cfg_t c);
    put_reg(REG_AIM_X, {7'($urandom()), c.aim_x});
    put_reg(REG_AIM_Y, {7'($urandom()), c.aim_y});
    put_reg(REG_STEER_GAIN, {4'($urandom()), c.steer_gain});
    put_reg(REG_POS_KP, c.pos_kp);
    put_reg(REG_POS_KD, c.pos_kd);
    put_reg(REG_SPD_KP, c.spd_kp);
    put_reg(REG_SPD_KI, c.spd_ki);
    put_reg(REG_NONE, 16'($urandom()));
    cfg_we <= 1'b0;
    active = c;
    walk_x = int'(c.aim_x);
    walk_y = int'(c.aim_y);
  endtask

  function automatic int bound(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // mostly small moves around the target, some re-centering, some noise
  task automatic random_items(input int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        walk_x = bound(walk_x + int'($urandom_range(0, 10)) - 5, 0, 511);
        walk_y = bound(walk_y + int'($urandom_range(0, 10)) - 5, 0, 511);
        walk_l = bound(walk_l + int'($urandom_range(0, 64)) - 32, -2048, 2047);
        walk_r = bound(walk_r + int'($urandom_range(0, 64)) - 32, -2048, 2047);
        send_item(walk_x, walk_y, walk_l, walk_r);
      end else if (roll < 76) begin
        walk_x = int'(active.aim_x);
        walk_y = int'(active.aim_y);
        walk_l = 0;
        walk_r = 0;
        send_item(walk_x, walk_y, walk_l, walk_r);
      end else begin
        send_item($urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end
  endtask

  initial begin
    cfg_t c;
    sb = new();
    active = sb.regs;
    walk_x = 160;
    walk_y = 160;
    walk_l = 0;
    walk_r = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(160, 160, 0, 0);
    send_item(0, 0, 0, 0);
    send_item(511, 511, 0, 0);
    send_item(320, 320, 2047, -2048);
    send_item(0, 511, -2048, 2047);
    send_item(511, 0, 2047, 2047);
    send_item(511, 0, -2048, -2048);
    send_item(160, 160, 0, 0);
    send_item(161, 159, 1, -1);
    send_item(170, 150, 100, -100);
    send_item(320, 0, -1, 0);
    send_item(0, 320, 0, -1);
    send_item(9'h155, 9'h0aa, 12'h555, 12'haaa);
    send_item(9'h0aa, 9'h155, 12'haaa, 12'h555);
    // drive both accumulators into the pwm limits and back
    repeat (4) send_item(0, 160, -2048, 2047);
    repeat (4) send_item(511, 160, 2047, -2048);
    repeat (2) send_item(160, 160, 0, 0);
    random_items(250);
    drain();

    for (int p = 1; p <= 6; p++) begin
      case (p)
        1: begin
          c.aim_x = 9'd0;
          c.aim_y = 9'd0;
          c.steer_gain = 12'hfff;
          c.pos_kp = 16'hffff;
          c.pos_kd = 16'hffff;
          c.spd_kp = 16'hffff;
          c.spd_ki = 16'hffff;
        end
        2: begin
          c.aim_x = 9'd511;
          c.aim_y = 9'd511;
          c.steer_gain = 12'd0;
          c.pos_kp = 16'd0;
          c.pos_kd = 16'd0;
          c.spd_kp = 16'd0;
          c.spd_ki = 16'd0;
        end
        3: begin
          c.aim_x = 9'd160;
          c.aim_y = 9'd160;
          c.steer_gain = 12'd256;
          c.pos_kp = 16'd6477;
          c.pos_kd = 16'd128;
          c.spd_kp = 16'd128;
          c.spd_ki = 16'd768;
        end
        6: begin
          c.aim_x = POS_W'($urandom_range(0, 511));
          c.aim_y = POS_W'($urandom_range(0, 511));
          c.steer_gain = TG_W'($urandom_range(0, 4095));
          c.pos_kp = GAIN_W'($urandom_range(0, 65535));
          c.pos_kd = GAIN_W'($urandom_range(0, 65535));
          c.spd_kp = GAIN_W'($urandom_range(0, 65535));
          c.spd_ki = GAIN_W'($urandom_range(0, 65535));
        end
        default: begin
          c.aim_x = POS_W'($urandom_range(0, 320));
          c.aim_y = POS_W'($urandom_range(0, 320));
          c.steer_gain = TG_W'($urandom_range(0, 4095));
          c.pos_kp = GAIN_W'($urandom_range(0, 8191));
          c.pos_kd = GAIN_W'($urandom_range(0, 2047));
          c.spd_kp = GAIN_W'($urandom_range(0, 1023));
          c.spd_ki = GAIN_W'($urandom_range(0, 2047));
        end
      endcase
      load_regs(c);
      quiet <= (p == 3);
      random_items(250);
      quiet <= 1'b0;
      drain();
    end

    if (sb.bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cpdd_pkg.sv
rtl/cpdd_cfg.sv
rtl/cpdd_mac.sv
rtl/cascaded_pid_differential_drive.sv
tb/sv/tb_cascaded_pid_differential_drive.sv
